// File: rtl/bfa_pkg.sv
// Shared types, constants and codes for the best-fit block allocator.
package bfa_pkg;

    // Arena geometry
    localparam int ARENA_BYTES    = 65536;
    localparam int PAGE_BYTES     = 4096;
    localparam int HEADER_BYTES   = 16;
    localparam int MAX_BLOCKS_DEF = 64;

    // Field widths
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 16;
    localparam int OFF_W  = $clog2(ARENA_BYTES + 1);
    localparam int EXT_W  = OFF_W + 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_BAD_ADDR = 2'd2
    } bfa_status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } bfa_state_t;

    // Request payload
    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] request_bytes;
        logic [ADDR_W-1:0] free_address;
    } bfa_in_t;

    // Result payload
    typedef struct packed {
        logic [ADDR_W-1:0] payload_address;
        logic [1:0]        status;
        logic              reused;
        logic [OFF_W-1:0]  break_offset;
    } bfa_out_t;

    // One block table entry
    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
    } bfa_entry_t;

endpackage

// File: rtl/bfa_table.sv
// Block table memory: one write port, one registered read port.
module bfa_table
    import bfa_pkg::*;
#(
    parameter int DEPTH = MAX_BLOCKS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  bfa_entry_t               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output bfa_entry_t               rd_data
);

    bfa_entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/best_fit_block_allocator_core.sv
// Top level of the best-fit block allocator: sequencer, scan and bookkeeping.
//
// Usage: configure heap_base through cfg_wr_en/cfg_wr_data while idle. Each
// request on in_valid/in_ready is an allocate (operation 0, request_bytes)
// or a free (operation 1, free_address); exactly one result follows on
// out_valid/out_ready with payload_address, status, reused and the break.
// Every request scans the block table, held in a synchronous RAM, one entry
// per cycle: an allocate keeps the smallest fitting free block (later block
// on a tie), a free looks for the entry whose payload sits at the address.
// One request is in work at a time; in_ready is high while idle, also while
// a result waits. If the receiver stalls, a finished request holds in the
// final state until the output register frees, and only then commits its
// table write.
// Reset clears the block count, heap top, break and heap_base; table
// entries are only read below the block count, so they need no clearing.
module best_fit_block_allocator_core
    import bfa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  bfa_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bfa_out_t          out_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // Control state
    bfa_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] heap_base_reg;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [OFF_W-1:0]  top_reg, top_next;
    logic [OFF_W-1:0]  brk_reg, brk_next;
    logic [CNT_W-1:0]  issue_idx_reg, issue_idx_next;
    logic              data_vld_reg;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    // Payload state
    logic              op_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [ADDR_W-1:0] off_reg;
    logic [IDX_W-1:0]  data_idx_reg;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    bfa_entry_t        best_ent_reg, best_ent_next;
    bfa_out_t          out_data_reg, out_data_next;

    // Table port signals
    logic              accept;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    bfa_entry_t        rd_ent;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    bfa_entry_t        wr_data;

    // Finish-stage arithmetic
    logic              fire;
    logic              slack_short;
    logic [EXT_W-1:0]  grow_bytes;
    logic [EXT_W-1:0]  new_break;
    logic [EXT_W-1:0]  new_top;
    logic [OFF_W-1:0]  new_off;
    logic              arena_over;
    logic              hit;

    bfa_table #(
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_ent)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Read issue: one entry per cycle below the block count
    assign rd_en   = (state_reg == ST_SCAN) && (issue_idx_reg < total_reg);
    assign rd_addr = issue_idx_reg[IDX_W-1:0];

    // Compare the entry returned by the table
    always_comb
    begin
        if (op_reg == OP_FREE)
        begin
            hit = data_vld_reg && !found_reg &&
                  (ADDR_W'(rd_ent.offset) == off_reg);
        end
        else
        begin
            hit = data_vld_reg && !rd_ent.used && (rd_ent.size >= req_reg) &&
                  (!found_reg || (rd_ent.size <= best_ent_reg.size));
        end
    end

    // Append arithmetic for an allocate with no fit
    assign fire        = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign slack_short = (top_reg > brk_reg) ||
                         ((brk_reg - top_reg) < OFF_W'(req_reg));
    assign grow_bytes  = (EXT_W'(req_reg >> PAGE_SHIFT) + EXT_W'(1)) << PAGE_SHIFT;
    assign new_break   = slack_short ? (EXT_W'(brk_reg) + grow_bytes) : EXT_W'(brk_reg);
    assign new_top     = EXT_W'(top_reg) + EXT_W'(HEADER_BYTES) + EXT_W'(req_reg);
    assign new_off     = top_reg + OFF_W'(HEADER_BYTES);
    assign arena_over  = (new_break > EXT_W'(ARENA_BYTES)) ||
                         (new_top > EXT_W'(ARENA_BYTES));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!rd_en && !data_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        total_next     = total_reg;
        top_next       = top_reg;
        brk_next       = brk_reg;
        issue_idx_next = issue_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_ent_next  = best_ent_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = best_idx_reg;
        wr_data        = best_ent_reg;

        case (state_reg)
            ST_IDLE:
            begin
                issue_idx_next = '0;
                found_next     = 1'b0;
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    found_next    = 1'b1;
                    best_idx_next = data_idx_reg;
                    best_ent_next = rd_ent;
                end
            end
            ST_FINISH:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.payload_address = '0;
                    out_data_next.status          = STATUS_OK;
                    out_data_next.reused          = 1'b0;
                    out_data_next.break_offset    = brk_reg;
                    if (op_reg == OP_FREE)
                    begin
                        if (found_reg)
                        begin
                            wr_en        = 1'b1;
                            wr_data.used = 1'b0;
                        end
                        else
                        begin
                            out_data_next.status = STATUS_BAD_ADDR;
                        end
                    end
                    else if (found_reg)
                    begin
                        // Reuse the best fitting free block
                        wr_en        = 1'b1;
                        wr_data.used = 1'b1;
                        out_data_next.payload_address =
                            heap_base_reg + ADDR_W'(best_ent_reg.offset);
                        out_data_next.reused = 1'b1;
                    end
                    else if ((total_reg == CNT_W'(MAX_BLOCKS)) || arena_over)
                    begin
                        out_data_next.status = STATUS_NO_SPACE;
                    end
                    else
                    begin
                        // Append a new block at the top
                        wr_en          = 1'b1;
                        wr_addr        = total_reg[IDX_W-1:0];
                        wr_data.used   = 1'b1;
                        wr_data.size   = req_reg;
                        wr_data.offset = new_off;
                        total_next     = total_reg + CNT_W'(1);
                        top_next       = new_top[OFF_W-1:0];
                        brk_next       = new_break[OFF_W-1:0];
                        out_data_next.payload_address = heap_base_reg + ADDR_W'(new_off);
                        out_data_next.break_offset    = new_break[OFF_W-1:0];
                    end
                end
            end
            default:
            begin
                issue_idx_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            heap_base_reg <= '0;
            total_reg     <= '0;
            top_reg       <= '0;
            brk_reg       <= '0;
            issue_idx_reg <= '0;
            data_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                heap_base_reg <= cfg_wr_data;
            end
            total_reg     <= total_next;
            top_reg       <= top_next;
            brk_reg       <= brk_next;
            issue_idx_reg <= issue_idx_next;
            data_vld_reg  <= rd_en;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= in_data.operation;
            req_reg <= in_data.request_bytes;
            off_reg <= in_data.free_address - heap_base_reg;
        end
        data_idx_reg <= rd_addr;
        best_idx_reg <= best_idx_next;
        best_ent_reg <= best_ent_next;
        out_data_reg <= out_data_next;
    end

    // Checks
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted request did not start a scan");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_arena_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (EXT_W'(top_reg) <= EXT_W'(ARENA_BYTES)) && (EXT_W'(brk_reg) <= EXT_W'(ARENA_BYTES)))
        else $error("heap top or break beyond arena");

    a_write_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> fire)
        else $error("table write outside the finish step");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && !out_ready)) |-> $past(fire))
        else $error("result appeared without a finished request");

endmodule

// File: verif/best_fit_block_allocator_core_test.sv
// Self-checking testbench for the best-fit block allocator core.
`timescale 1ns / 1ps

module best_fit_block_allocator_core_test
    import bfa_pkg::*;
();

    localparam int CYCLE_LIMIT = 800000;
    localparam int HOLD_OFF_CYCLES = 400;

    // Mirror of the allocator: block table, heap top, break and the grants still owed
    class alloc_scoreboard;
        logic [ADDR_W-1:0] heap_base;
        logic              blk_used [MAX_BLOCKS_DEF];
        logic [SIZE_W-1:0] blk_size [MAX_BLOCKS_DEF];
        logic [OFF_W-1:0]  blk_off  [MAX_BLOCKS_DEF];
        int                blk_count;
        int                heap_top;
        int                break_end;
        bfa_out_t          pending_grants[$];
        int                mismatches;
        int                requests;
        int                reuses;
        int                appends;
        int                no_space;
        int                bad_frees;

        function new();
            heap_base = '0;
            blk_count = 0;
            heap_top = 0;
            break_end = 0;
            mismatches = 0;
            requests = 0;
            reuses = 0;
            appends = 0;
            no_space = 0;
            bad_frees = 0;
        endfunction

        function logic [ADDR_W-1:0] block_address(int idx);
            return heap_base + ADDR_W'(blk_off[idx]);
        endfunction

        // Work out the grant for an accepted request and update the mirror
        function void note_request(bfa_in_t r);
            bfa_out_t          want;
            int                i;
            int                req;
            int                best;
            int                pick;
            int                new_break;
            int                new_top;
            bit                found;
            logic [ADDR_W-1:0] rel;

            want = '0;
            found = 1'b0;
            requests++;
            if (r.operation == OP_ALLOC)
            begin
                req = int'(r.request_bytes);
                best = 32'h7FFF_FFFF;
                pick = 0;
                // best fit, later block wins a tie
                for (i = 0; i < blk_count; i++)
                begin
                    if (!blk_used[i] && int'(blk_size[i]) >= req && int'(blk_size[i]) <= best)
                    begin
                        best = int'(blk_size[i]);
                        pick = i;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    blk_used[pick] = 1'b1;
                    want.payload_address = block_address(pick);
                    want.reused = 1'b1;
                    want.status = STATUS_OK;
                    reuses++;
                end
                else if (blk_count >= MAX_BLOCKS_DEF)
                begin
                    want.status = STATUS_NO_SPACE;
                    no_space++;
                end
                else
                begin
                    // slack check leaves the header out
                    new_break = break_end;
                    if (heap_top > break_end || break_end - heap_top < req)
                        new_break = break_end + (1 + req / PAGE_BYTES) * PAGE_BYTES;
                    new_top = heap_top + HEADER_BYTES + req;
                    if (new_break > ARENA_BYTES || new_top > ARENA_BYTES)
                    begin
                        want.status = STATUS_NO_SPACE;
                        no_space++;
                    end
                    else
                    begin
                        break_end = new_break;
                        blk_used[blk_count] = 1'b1;
                        blk_size[blk_count] = r.request_bytes;
                        blk_off[blk_count] = OFF_W'(heap_top + HEADER_BYTES);
                        want.payload_address = block_address(blk_count);
                        want.status = STATUS_OK;
                        blk_count++;
                        heap_top = new_top;
                        appends++;
                    end
                end
            end
            else
            begin
                rel = r.free_address - heap_base;
                for (i = 0; i < blk_count && !found; i++)
                begin
                    if (ADDR_W'(blk_off[i]) == rel)
                    begin
                        blk_used[i] = 1'b0;
                        found = 1'b1;
                    end
                end
                want.status = found ? STATUS_OK : STATUS_BAD_ADDR;
                if (!found)
                    bad_frees++;
            end
            want.break_offset = OFF_W'(break_end);
            pending_grants.push_back(want);
        endfunction

        // Compare a delivered result with the oldest grant owed
        function void check_result(bfa_out_t got);
            bfa_out_t want;

            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: addr %h status %0d reused %0d break %h",
                             got.payload_address, got.status, got.reused, got.break_offset);
                return;
            end
            want = pending_grants.pop_front();
            if (got.payload_address !== want.payload_address || got.status !== want.status ||
                got.reused !== want.reused || got.break_offset !== want.break_offset)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch: expected addr %h status %0d reused %0d break %h",
                             want.payload_address, want.status, want.reused,
                             want.break_offset);
                    $display("                 actual   addr %h status %0d reused %0d break %h",
                             got.payload_address, got.status, got.reused, got.break_offset);
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0] cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    bfa_in_t           in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    bfa_out_t          out_data;

    alloc_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_off_wanted = 0;
    bit  hold_off_started = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;
    int  base_settings = 0;

    best_fit_block_allocator_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    always #1 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_grants.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_off_wanted != 0 && !hold_off_started)
        begin
            hold_left = hold_off_wanted;
            hold_off_started = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    function automatic bfa_in_t make_req(logic op, logic [SIZE_W-1:0] bytes,
                                         logic [ADDR_W-1:0] addr);
        bfa_in_t r;

        r.operation = op;
        r.request_bytes = bytes;
        r.free_address = addr;
        return r;
    endfunction

    // Random request: mostly allocates and frees of table blocks, some noise
    function automatic bfa_in_t random_request();
        bfa_in_t r;
        int      pick;
        int      k;

        r.operation = OP_ALLOC;
        r.request_bytes = SIZE_W'($urandom);
        r.free_address = $urandom;
        pick = $urandom_range(99);
        k = $urandom_range(99);
        if (sb.blk_count == 0 || pick < 50)
        begin
            if (k < 40)
                r.request_bytes = SIZE_W'($urandom_range(255));
            else if (k < 65)
                r.request_bytes = SIZE_W'($urandom_range(15) * 16);
            else if (k < 80)
                r.request_bytes = (sb.blk_count > 0) ?
                    sb.blk_size[$urandom_range(sb.blk_count - 1)] : SIZE_W'($urandom_range(63));
            else if (k < 92)
                r.request_bytes = SIZE_W'($urandom_range(4095, 256));
            // whole range only once the table is full, so the arena is not eaten early
            else if (sb.blk_count < MAX_BLOCKS_DEF)
                r.request_bytes = SIZE_W'($urandom_range(63));
        end
        else if (pick < 90)
        begin
            r.operation = OP_FREE;
            r.free_address = sb.block_address($urandom_range(sb.blk_count - 1));
        end
        else
        begin
            r.operation = OP_FREE;
            if (k < 50)
                r.free_address = sb.block_address($urandom_range(sb.blk_count - 1)) +
                                 $urandom_range(8, 1);
        end
        return r;
    endfunction

    // Offer one request, with random idle cycles first; note it once accepted
    task automatic send_request(bfa_in_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
    endtask

    // Stop offering and wait for every owed result
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_heap_base(logic [ADDR_W-1:0] value);
        in_valid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.heap_base = value;
        base_settings++;
        @(posedge clk);
    endtask

    task automatic run_phase(int count, int idle_pct, int stall);
        int n;

        send_idle_pct = idle_pct;
        stall_pct = stall;
        for (n = 0; n < count; n++)
            send_request(random_request());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: base close to the top so payload addresses wrap
        write_heap_base(32'hFFFF_FF00);
        send_request(make_req(OP_ALLOC, 16'd0, '0));        // zero bytes, break left at 0
        send_request(make_req(OP_ALLOC, 16'd0, '0));        // top above break
        send_request(make_req(OP_ALLOC, 16'd4095, '0));
        send_request(make_req(OP_ALLOC, 16'hFFFF, '0));     // top past the arena
        send_request(make_req(OP_ALLOC, 16'd61440, '0));    // break past the arena
        send_request(make_req(OP_FREE, '0, sb.block_address(0)));
        send_request(make_req(OP_FREE, '0, sb.block_address(0)));   // already free
        send_request(make_req(OP_FREE, '0, sb.block_address(0) + 1));
        send_request(make_req(OP_ALLOC, 16'd0, '0));
        send_request(make_req(OP_FREE, '0, sb.block_address(2)));
        send_request(make_req(OP_FREE, '0, sb.block_address(1)));
        send_request(make_req(OP_ALLOC, 16'd0, '0));
        send_request(make_req(OP_ALLOC, 16'd1, '0));
        send_request(make_req(OP_ALLOC, 16'd4096, '0));
        send_request(make_req(OP_FREE, '0, sb.block_address(3)));
        send_request(make_req(OP_ALLOC, 16'd100, '0));
        // two equal free blocks: the later one goes first
        send_request(make_req(OP_FREE, '0, sb.block_address(0)));
        send_request(make_req(OP_FREE, '0, sb.block_address(1)));
        send_request(make_req(OP_ALLOC, 16'd0, '0));
        send_request(make_req(OP_ALLOC, 16'd0, '0));
        send_request(make_req(OP_FREE, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(make_req(OP_FREE, 16'h0000, 32'h0000_0000));
        send_request(make_req(OP_ALLOC, 16'd8, 32'hFFFF_FFFF));
        wait_drained();

        // Random, no idling; a long hold-off fills the block, then a full pause
        write_heap_base(32'h0000_0000);
        run_phase(150, 0, 0);
        hold_off_wanted = HOLD_OFF_CYCLES;
        run_phase(30, 0, 0);
        wait_drained();
        run_phase(120, 0, 0);
        wait_drained();

        write_heap_base(32'hFFFF_FFFF);
        run_phase(280, 65, 0);
        wait_drained();

        write_heap_base($urandom);
        run_phase(280, 0, 65);
        wait_drained();

        write_heap_base($urandom);
        run_phase(280, 17, 17);
        wait_drained();
        repeat (MAX_BLOCKS_DEF + 16) @(posedge clk);

        $display("%0d requests under %0d heap_base settings: %0d appends, %0d reuses,",
                 sb.requests, base_settings, sb.appends, sb.reuses);
        $display("%0d refused for space or table, %0d frees of unknown addresses",
                 sb.no_space, sb.bad_frees);
        if (sb.mismatches == 0 && sb.pending_grants.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
